// ===== src/pat_pkg.sv =====
package pat_pkg;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int TIME_W  = 63;
	localparam int PMS_W   = 32;
	localparam int PER_W   = 42;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 3;
	localparam int TV_W    = 64;
	localparam int STAT_W  = 2;
	localparam int USEC_W  = 10;

	// Packed stream widths
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 72;

	// Defaults for the top level parameters
	localparam int DEF_MAX_ALARMS         = 8;
	localparam int DEF_MAX_FIRES_PER_POLL = 63;

	localparam logic [TIME_W-1:0] TIME_MAX      = '1;
	localparam logic [USEC_W-1:0] USEC_PER_MSEC = USEC_W'(1000);

	// Commands
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POLL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLEEP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO = 2'd3;

endpackage

// ===== src/periodic_alarm_table_top.sv =====
// Periodic alarm table. Each command arrives as one transfer on the slave stream
// (tuser = command, tdata = now and period in ms) and produces one or more result
// transfers on the master stream, the final one marked by tlast. Add stores an
// alarm with deadline now + period_ms*1000 and answers with its slot and deadline,
// or with a status of zero period, table full or deadline overflow. Poll walks the
// alarms from newest to oldest and reports every firing, one result per firing,
// capped at MAX_FIRES_PER_POLL with more_pending set on the closing result; a
// deadline that would pass the largest time saturates there and that firing
// carries the overflow status. Sleep query answers -1 with no alarms, 0 if one is
// due, else the time to the earliest deadline. Periods and deadlines live in two
// single-port-read RAMs with a registered read, so every alarm visited costs a
// read before it can be checked, and the master side can stall any result. One
// command is worked at a time; the next is taken as soon as the last result of
// the current one is in the output register, even while that result still waits.
// No clearing pass is needed after reset: only slots below the alarm count are
// ever read.
module periodic_alarm_table_top
	import pat_pkg::*;
#(
	parameter int MAX_ALARMS         = DEF_MAX_ALARMS,
	parameter int MAX_FIRES_PER_POLL = DEF_MAX_FIRES_PER_POLL
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // now[62:0], period_ms[94:63], zero[95]
	input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // alarm_index[2:0], time_value[66:3],
	                                             // fired_any[67], more_pending[68],
	                                             // status[70:69], zero[71]
	output logic [KIND_W-1:0]     m_axis_tuser,  // kind[1:0]
	output logic                  m_axis_tlast
);

	localparam int CW = $clog2(MAX_ALARMS + 1);
	localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
	localparam int FW = $clog2(MAX_FIRES_PER_POLL + 1);

	// Sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ADD_MUL = 4'd1;
	localparam logic [3:0] ST_ADD_CHK = 4'd2;
	localparam logic [3:0] ST_P_START = 4'd3;
	localparam logic [3:0] ST_P_RD    = 4'd4;
	localparam logic [3:0] ST_P_LD    = 4'd5;
	localparam logic [3:0] ST_P_EV    = 4'd6;
	localparam logic [3:0] ST_P_FIN   = 4'd7;
	localparam logic [3:0] ST_S_START = 4'd8;
	localparam logic [3:0] ST_S_RD    = 4'd9;
	localparam logic [3:0] ST_S_CMP   = 4'd10;
	localparam logic [3:0] ST_S_OUT   = 4'd11;

	logic [3:0]        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [FW-1:0]     fires_q, fires_d;
	logic              pend_q, pend_d;

	// Command and working registers
	logic [CMD_W-1:0]  cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [PMS_W-1:0]  pms_q;
	logic [PER_W-1:0]  per_q, per_d;
	logic [TIME_W-1:0] dl_q, dl_d;
	logic [TIME_W-1:0] best_q, best_d;

	// Output register
	logic              m_valid_q;
	logic [KIND_W-1:0] o_kind_q, o_kind;
	logic [IDX_W-1:0]  o_idx_q, o_idx;
	logic [TV_W-1:0]   o_time_q, o_time;
	logic              o_fired_q, o_fired;
	logic              o_more_q, o_more;
	logic [STAT_W-1:0] o_stat_q, o_stat;
	logic              o_last_q, o_last;
	logic              out_load, out_free;

	// RAM ports
	logic              per_we, dl_we;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [TIME_W-1:0] dl_wdata;
	logic [PER_W-1:0]  per_rdata;
	logic [TIME_W-1:0] dl_rdata;

	logic              in_xfer;
	logic [TV_W-1:0]   add_sum, adv_sum;
	logic [CW-1:0]     slot;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	assign add_sum = {1'b0, now_q} + TV_W'(per_q);
	assign adv_sum = {1'b0, dl_q} + TV_W'(per_q);
	assign slot    = idx_q - CW'(1);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		fires_d  = fires_q;
		pend_d   = pend_q;
		per_d    = per_q;
		dl_d     = dl_q;
		best_d   = best_q;
		out_load = 1'b0;
		o_kind   = KIND_FIRE;
		o_idx    = '0;
		o_time   = '0;
		o_fired  = 1'b0;
		o_more   = 1'b0;
		o_stat   = STAT_OK;
		o_last   = 1'b1;
		per_we   = 1'b0;
		dl_we    = 1'b0;
		wr_addr  = AW'(cnt_q);
		dl_wdata = add_sum[TIME_W-1:0];
		rd_addr  = AW'(idx_q);

		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (s_axis_tuser)
						CMD_ADD:   state_d = ST_ADD_MUL;
						CMD_POLL:  state_d = ST_P_START;
						CMD_SLEEP: state_d = ST_S_START;
						default:   state_d = ST_IDLE;  // drop unknown commands
					endcase
				end
			end
			ST_ADD_MUL: begin
				per_d   = PER_W'(pms_q) * PER_W'(USEC_PER_MSEC);
				state_d = ST_ADD_CHK;
			end
			ST_ADD_CHK: begin
				o_kind = KIND_ADD;
				if (pms_q == '0) begin
					o_stat = STAT_ZERO;
				end else if (cnt_q >= CW'(MAX_ALARMS)) begin
					o_stat = STAT_FULL;
				end else if (add_sum[TV_W-1]) begin
					o_stat = STAT_OVF;
				end else begin
					o_idx  = IDX_W'(cnt_q);
					o_time = add_sum;
				end
				if (out_free) begin
					out_load = 1'b1;
					if (o_stat == STAT_OK) begin
						per_we = 1'b1;
						dl_we  = 1'b1;
						cnt_d  = cnt_q + CW'(1);
					end
					state_d = ST_IDLE;
				end
			end
			ST_P_START: begin
				idx_d   = cnt_q;
				fires_d = '0;
				pend_d  = 1'b0;
				state_d = (cnt_q == '0) ? ST_P_FIN : ST_P_RD;
			end
			ST_P_RD: begin
				rd_addr = AW'(slot);
				state_d = ST_P_LD;
			end
			ST_P_LD: begin
				dl_d    = dl_rdata;
				per_d   = per_rdata;
				state_d = ST_P_EV;
			end
			ST_P_EV: begin
				if (dl_q > now_q) begin
					// not due: step to the next older alarm
					idx_d   = slot;
					state_d = (idx_q == CW'(1)) ? ST_P_FIN : ST_P_RD;
				end else if (fires_q >= FW'(MAX_FIRES_PER_POLL)) begin
					pend_d  = 1'b1;
					state_d = ST_P_FIN;
				end else if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_FIRE;
					o_idx    = IDX_W'(slot);
					o_time   = TV_W'(dl_q);
					o_last   = 1'b0;
					// advance the deadline, saturate on overflow
					if (adv_sum[TV_W-1]) begin
						o_stat = STAT_OVF;
						dl_d   = TIME_MAX;
					end else begin
						dl_d   = adv_sum[TIME_W-1:0];
					end
					dl_we    = 1'b1;
					wr_addr  = AW'(slot);
					dl_wdata = dl_d;
					fires_d  = fires_q + FW'(1);
				end
			end
			ST_P_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_POLL;
					o_fired  = (fires_q != '0);
					o_more   = pend_q;
					state_d  = ST_IDLE;
				end
			end
			ST_S_START: begin
				idx_d  = '0;
				best_d = TIME_MAX;
				if (cnt_q != '0) begin
					state_d = ST_S_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_SLEEP;
					o_time   = '1;
					state_d  = ST_IDLE;
				end
			end
			ST_S_RD: begin
				idx_d   = idx_q + CW'(1);
				state_d = ST_S_CMP;
			end
			ST_S_CMP: begin
				if (dl_rdata < best_q) begin
					best_d = dl_rdata;
				end
				state_d = (idx_q == cnt_q) ? ST_S_OUT : ST_S_RD;
			end
			ST_S_OUT: begin
				o_kind = KIND_SLEEP;
				o_time = (best_q <= now_q) ? '0 : TV_W'(best_q - now_q);
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			fires_q   <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			fires_q <= fires_d;
			pend_q  <= pend_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload: no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= s_axis_tuser;
			now_q <= s_axis_tdata[TIME_W-1:0];
			pms_q <= s_axis_tdata[TIME_W+PMS_W-1:TIME_W];
		end
		per_q  <= per_d;
		dl_q   <= dl_d;
		best_q <= best_d;
		if (out_load) begin
			o_kind_q  <= o_kind;
			o_idx_q   <= o_idx;
			o_time_q  <= o_time;
			o_fired_q <= o_fired;
			o_more_q  <= o_more;
			o_stat_q  <= o_stat;
			o_last_q  <= o_last;
		end
	end

	pat_ram #(
		.WIDTH (PER_W),
		.DEPTH (MAX_ALARMS)
	) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (wr_addr),
		.wdata (per_q),
		.raddr (rd_addr),
		.rdata (per_rdata)
	);

	pat_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_ALARMS)
	) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (wr_addr),
		.wdata (dl_wdata),
		.raddr (rd_addr),
		.rdata (dl_rdata)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {1'b0, o_stat_q, o_more_q, o_fired_q, o_time_q, o_idx_q};

	// The command register steers nothing; keep it visible for debug.
	logic cmd_unknown;
	assign cmd_unknown = (cmd_q != CMD_ADD) && (cmd_q != CMD_POLL) && (cmd_q != CMD_SLEEP);

	// Alarm count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ALARMS))
		else $error("alarm count above table size");

	// Firings per poll never pass the cap
	assert property (@(posedge clk) disable iff (!arst_n)
		fires_q <= FW'(MAX_FIRES_PER_POLL))
		else $error("fire count above cap");

	// RAM writes happen only together with a result transfer into the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(dl_we || per_we) |-> out_load)
		else $error("table write without result");

	// A successful add bumps the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && o_kind == KIND_ADD && o_stat == STAT_OK) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("add did not advance count");

	// A fired deadline is never negative nor the final result, and its command is known
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && o_kind_q == KIND_FIRE) |-> (!o_time_q[TV_W-1] && !o_last_q && !cmd_unknown))
		else $error("bad firing result");

endmodule

// ===== src/pat_ram.sv =====
module pat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== test/tb_periodic_alarm_table_top.sv =====
module tb_periodic_alarm_table_top;
	import pat_pkg::*;

	localparam int N_SLOTS      = DEF_MAX_ALARMS;
	localparam int FIRE_CAP     = DEF_MAX_FIRES_PER_POLL;
	localparam int N_RANDOM     = 96;
	localparam int MAX_GAP      = 12;
	localparam int RESET_CYCLES = 8;
	// Drain time sized for a full poll with eight alarms; leave margin for stalls.
	localparam int DRAIN_CYCLES = 40;
	// Worst case: every command yields 64 results, each held off by the longest sink stall.
	localparam longint RUN_LIMIT = 64'd10_000_000;

	// The block has no command 3; it must swallow such a transfer without a result.
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// One result transfer, unpacked from the master stream.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [TV_W-1:0]   tval;
		logic              fired;
		logic              more;
		logic [STAT_W-1:0] status;
		logic              last;
	} alarm_out_t;

	// One directed command; when typed is set, res is the single result it must produce.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] now;
		logic [PMS_W-1:0]  pms;
		logic              typed;
		alarm_out_t        res;
	} cmd_row_t;

	localparam alarm_out_t NO_RES          = '0;
	localparam alarm_out_t RES_SLEEP_EMPTY = '{KIND_SLEEP, 3'd0, '1, 1'b0, 1'b0, STAT_OK, 1'b1};
	localparam alarm_out_t RES_POLL_IDLE   = '{KIND_POLL, 3'd0, '0, 1'b0, 1'b0, STAT_OK, 1'b1};
	localparam alarm_out_t RES_ADD_ZERO    = '{KIND_ADD, 3'd0, '0, 1'b0, 1'b0, STAT_ZERO, 1'b1};
	localparam alarm_out_t RES_ADD_FULL    = '{KIND_ADD, 3'd0, '0, 1'b0, 1'b0, STAT_FULL, 1'b1};
	localparam alarm_out_t RES_ADD_OVF     = '{KIND_ADD, 3'd0, '0, 1'b0, 1'b0, STAT_OVF, 1'b1};

	localparam logic [PMS_W-1:0] PMS_MAX = '1;

	// Directed walk. Slots fill in order: 0 saturates at the largest time, 1 runs at
	// 1 ms, 2 at the longest period, 3 at 3 ms, 4 and 5 at 7 and 50 ms, 6 sits just
	// below the largest time, 7 at 1 ms fills the table.
	localparam cmd_row_t DIR_ROWS [23] = '{
		'{CMD_SLEEP, 63'd0, 32'd0, 1'b1, RES_SLEEP_EMPTY},     // empty table: -1
		'{CMD_POLL, 63'd0, 32'd0, 1'b1, RES_POLL_IDLE},        // empty table: nothing fires
		'{CMD_ADD, 63'd5, 32'd0, 1'b1, RES_ADD_ZERO},          // zero period
		'{CMD_ADD, TIME_MAX, PMS_MAX, 1'b1, RES_ADD_OVF},      // deadline past the largest time
		'{CMD_ADD, TIME_MAX - 63'd1000, 32'd1, 1'b0, NO_RES},  // deadline exactly at the top
		'{CMD_ADD, 63'd0, 32'd1, 1'b0, NO_RES},
		'{CMD_NONE, TIME_MAX, PMS_MAX, 1'b0, NO_RES},          // unknown command: no result
		'{CMD_SLEEP, 63'd400, 32'd0, 1'b0, NO_RES},
		'{CMD_POLL, 63'd1000, 32'd0, 1'b0, NO_RES},            // deadline equal to now fires
		'{CMD_ADD, 63'd0, PMS_MAX, 1'b0, NO_RES},
		'{CMD_ADD, 63'd1000, 32'd3, 1'b0, NO_RES},
		'{CMD_POLL, 63'd200000, 32'd0, 1'b0, NO_RES},          // hits the fire cap
		'{CMD_POLL, 63'd200000, 32'd0, 1'b0, NO_RES},          // continues where the cap stopped
		'{CMD_SLEEP, 63'd200000, 32'd0, 1'b0, NO_RES},         // alarm still due: 0
		'{CMD_ADD, 63'd2000, 32'd7, 1'b0, NO_RES},
		'{CMD_ADD, 63'd2000, 32'd50, 1'b0, NO_RES},
		'{CMD_ADD, TIME_MAX - 63'd5000, 32'd2, 1'b0, NO_RES},
		'{CMD_POLL, TIME_MAX, 32'd0, 1'b0, NO_RES},            // advance saturates at the top
		'{CMD_SLEEP, TIME_MAX, 32'd0, 1'b0, NO_RES},
		'{CMD_ADD, 63'd3000, 32'd1, 1'b0, NO_RES},             // eighth alarm
		'{CMD_ADD, 63'd3000, 32'd1, 1'b1, RES_ADD_FULL},       // table full
		'{CMD_ADD, 63'd3000, 32'd0, 1'b1, RES_ADD_ZERO},       // zero period wins over full
		'{CMD_POLL, 63'd0, 32'd0, 1'b0, NO_RES}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // now[62:0], period_ms[94:63], zero[95]
	logic [CMD_W-1:0]      s_axis_tuser = '0;   // cmd[1:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // alarm_index[2:0], time_value[66:3],
	                                            // fired_any[67], more_pending[68],
	                                            // status[70:69], zero[71]
	logic [KIND_W-1:0]     m_axis_tuser;        // kind[1:0]
	logic                  m_axis_tlast;

	// Shadow copy of the alarm table, advanced once per accepted command.
	logic [PER_W-1:0]  shadow_period   [N_SLOTS];
	logic [TIME_W-1:0] shadow_deadline [N_SLOTS];
	int unsigned       shadow_count = 0;

	alarm_out_t alarm_reports [$];   // results still owed by the block, oldest first
	int         n_bad  = 0;
	int         n_seen = 0;
	bit         src_calm  = 1'b0;
	bit         sink_calm = 1'b0;

	periodic_alarm_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Work out the results of one command against the shadow table and update it.
	function automatic void alarm_table_step(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] now, input logic [PMS_W-1:0] pms,
			output alarm_out_t outs [$]);
		logic [63:0] per64;
		logic [63:0] d;
		logic [63:0] best;
		int unsigned fires;
		bit          pend;
		alarm_out_t  r;
		outs = {};
		r = '0;
		r.last = 1'b1;
		case (cmd)
		CMD_ADD: begin
			r.kind = KIND_ADD;
			per64 = 64'(PER_W'(64'(pms) * 64'(USEC_PER_MSEC)));
			// Check order matters: zero period, then full, then overflow.
			if (pms == '0)
				r.status = STAT_ZERO;
			else if (shadow_count >= N_SLOTS)
				r.status = STAT_FULL;
			else if (64'(TIME_MAX) - 64'(now) < per64)
				r.status = STAT_OVF;
			else begin
				shadow_period[shadow_count]   = per64[PER_W-1:0];
				shadow_deadline[shadow_count] = now + per64[TIME_W-1:0];
				r.idx  = IDX_W'(shadow_count);
				r.tval = 64'(now) + per64;
				shadow_count++;
			end
			outs.push_back(r);
		end
		CMD_POLL: begin
			fires = 0;
			pend  = 1'b0;
			// Walk newest to oldest; an alarm keeps firing until its deadline passes now.
			for (int i = int'(shadow_count) - 1; i >= 0 && !pend; i--) begin
				while (shadow_deadline[i] <= now) begin
					if (fires >= FIRE_CAP) begin
						pend = 1'b1;
						break;
					end
					d = 64'(shadow_deadline[i]);
					r = '0;
					r.kind = KIND_FIRE;
					r.idx  = IDX_W'(i);
					r.tval = d;
					if (64'(TIME_MAX) - d < 64'(shadow_period[i])) begin
						shadow_deadline[i] = TIME_MAX;
						r.status = STAT_OVF;
					end else begin
						shadow_deadline[i] = shadow_deadline[i] + TIME_W'(shadow_period[i]);
					end
					outs.push_back(r);
					fires++;
				end
			end
			r = '0;
			r.kind  = KIND_POLL;
			r.fired = (fires > 0);
			r.more  = pend;
			r.last  = 1'b1;
			outs.push_back(r);
		end
		CMD_SLEEP: begin
			r.kind = KIND_SLEEP;
			if (shadow_count == 0) begin
				r.tval = '1;
			end else begin
				best = 64'(TIME_MAX);
				for (int k = 0; k < int'(shadow_count); k++)
					if (64'(shadow_deadline[k]) < best)
						best = 64'(shadow_deadline[k]);
				r.tval = (best <= 64'(now)) ? '0 : best - 64'(now);
			end
			outs.push_back(r);
		end
		default: ;
		endcase
	endfunction

	task automatic report_bad(input string what, input logic [63:0] got,
			input logic [63:0] want);
		// Keep the log bounded if the block is badly off; count every one.
		if (n_bad < 100)
			$display("mismatch at result %0d: %s got %h want %h", n_seen, what, got, want);
		n_bad++;
	endtask

	// Present one command, hold it until the transfer, then log what it owes.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
			input logic [PMS_W-1:0] pms, input logic typed, input alarm_out_t typed_res);
		int         gap;
		alarm_out_t outs [$];
		if ($urandom_range(0, 15) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
		// Drop valid only when a gap follows, so back-to-back transfers keep it high.
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, pms, now};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (s_axis_tready !== 1'b1) @(posedge clk);
		alarm_table_step(cmd, now, pms, outs);
		if (typed)
			alarm_reports.push_back(typed_res);
		else
			foreach (outs[k]) alarm_reports.push_back(outs[k]);
	endtask

	initial begin : result_sink
		int         stall;
		alarm_out_t got;
		alarm_out_t want;
		forever begin
			if ($urandom_range(0, 15) == 0)
				sink_calm = !sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (m_axis_tvalid !== 1'b1) @(posedge clk);
			// Unpack the transfer seen at this edge.
			got.kind   = m_axis_tuser;
			got.idx    = m_axis_tdata[2:0];
			got.tval   = m_axis_tdata[66:3];
			got.fired  = m_axis_tdata[67];
			got.more   = m_axis_tdata[68];
			got.status = m_axis_tdata[70:69];
			got.last   = m_axis_tlast;
			n_seen++;
			if (alarm_reports.size() == 0) begin
				report_bad("result with nothing owed, time_value", got.tval, '0);
			end else begin
				want = alarm_reports.pop_front();
				if (got.kind !== want.kind)     report_bad("kind", got.kind, want.kind);
				if (got.idx !== want.idx)       report_bad("alarm_index", got.idx, want.idx);
				if (got.tval !== want.tval)     report_bad("time_value", got.tval, want.tval);
				if (got.fired !== want.fired)   report_bad("fired_any", got.fired, want.fired);
				if (got.more !== want.more)     report_bad("more_pending", got.more, want.more);
				if (got.status !== want.status) report_bad("status", got.status, want.status);
				if (got.last !== want.last)     report_bad("last", got.last, want.last);
			end
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] now;
		logic [PMS_W-1:0]  pms;
		logic [CMD_W-1:0]  cmd;
		int                counted;
		int                pick;
		// Hold reset, then release it on a rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_cmd(DIR_ROWS[i].cmd, DIR_ROWS[i].now, DIR_ROWS[i].pms,
				DIR_ROWS[i].typed, DIR_ROWS[i].res);

		// Random part: a scheduler timeline that mostly moves forward, so polls keep
		// finding late alarms and the fire cap comes up often; mix in adds on a
		// full table, adds near the top of time and full-range noise.
		t = 63'd200000;
		counted = 0;
		while (counted < N_RANDOM) begin
			pick = $urandom_range(0, 99);
			now  = t;
			pms  = $urandom;
			cmd  = CMD_POLL;
			if (pick < 45) begin
				cmd = CMD_POLL;
			end else if (pick < 70) begin
				cmd = CMD_SLEEP;
			end else if (pick < 80) begin
				cmd = CMD_ADD;
				if ($urandom_range(0, 3) == 0)
					pms = '0;
			end else if (pick < 90) begin
				cmd = CMD_W'($urandom_range(0, 3));
				now = TIME_W'({$urandom, $urandom});
			end else begin
				cmd = CMD_ADD;
				now = TIME_MAX - TIME_W'($urandom_range(0, 5000));
				pms = PMS_W'($urandom_range(0, 9));
			end
			send_cmd(cmd, now, pms, 1'b0, NO_RES);
			if (cmd != CMD_NONE)
				counted++;
			// Sometimes poll again at the same time to pick up a capped poll.
			if ($urandom_range(0, 9) < 7)
				t = t + TIME_W'($urandom_range(0, 20000));
		end
		s_axis_tvalid <= 1'b0;

		// Drain: wait for every owed result, then give the block time to misbehave.
		while (alarm_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_bad == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pat_pkg.sv
src/pat_ram.sv
src/periodic_alarm_table_top.sv
test/tb_periodic_alarm_table_top.sv
